// ===== src/mlet_pkg.sv =====
package mlet_pkg;

  localparam int X_BITS     = 16;
  localparam int NODE_COUNT = 4096;

  localparam int IDX_W  = $clog2(NODE_COUNT);
  localparam int CNT_W  = $clog2(NODE_COUNT + 1);
  localparam int LVL_W  = $clog2(X_BITS + 1);
  localparam int BIT_W  = $clog2(X_BITS);
  localparam int PROD_W = X_BITS + 33;

  localparam logic signed [63:0] ROOT_ICPT = -64'sd1000000000000000000;
  localparam logic signed [63:0] VAL_MIN   = {1'b1, {63{1'b0}}};
  localparam logic signed [63:0] VAL_MAX   = {1'b0, {63{1'b1}}};

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_QUERY  = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_t;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_EVAL  = 6'b000010,
    ST_RD    = 6'b000100,
    ST_LOAD  = 6'b001000,
    ST_WB    = 6'b010000,
    ST_ALLOC = 6'b100000
  } state_t;

  // child index 0 means no child: the root is never a child
  typedef struct packed {
    logic signed [31:0] slope;
    logic signed [63:0] icpt;
    logic [IDX_W-1:0]   left;
    logic [IDX_W-1:0]   right;
  } node_t;

  localparam int NODE_W = $bits(node_t);

  localparam node_t ROOT_NODE = '{slope: 32'sd0, icpt: ROOT_ICPT, left: '0, right: '0};

endpackage

// ===== src/mlet_ram.sv =====
module mlet_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/max_line_envelope_tree.sv =====
// Max line envelope (Li Chao tree) over x in 0 .. 2^X_BITS-1, lines y = slope*x + intercept.
// A request is taken when start is high and busy is low; each request gives exactly one
// result, shown for one cycle with out_valid high, and the receiver cannot hold it off.
// Clear and the no-op command finish in the accept cycle, result on the next cycle.
// A query or an insert keeps busy high while it walks down the tree level by level, at most
// X_BITS levels; an insert passes through ST_ALLOC as well when it allocates a node.
// The time per level is set by the single multiply-add evaluator, which handles one line
// evaluation per cycle (six per insert level, one per query level), and by the one
// read port of the node RAM, which adds a load state on every descent. The root lives
// in flip-flops; the other nodes sit in RAM and are only reached once allocated, so
// clear just resets the root and the fill count and needs no sweep.
module max_line_envelope_tree import mlet_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_command,
  input  logic signed [31:0] in_slope,
  input  logic signed [47:0] in_intercept,
  input  logic [15:0]        in_position,
  output logic               out_valid,
  output logic signed [63:0] out_value,
  output logic               out_status
);

  state_t             state_r, state_nxt;
  logic [2:0]         cnt_r, cnt_nxt;
  logic               query_r, query_nxt;
  node_t              root_r, root_nxt;
  node_t              node_r, node_nxt;
  logic signed [31:0] cur_s_r, cur_s_nxt;
  logic signed [63:0] cur_c_r, cur_c_nxt;
  logic [IDX_W-1:0]   v_r, v_nxt;
  logic [IDX_W-1:0]   child_r, child_nxt;
  logic [X_BITS-1:0]  lo_r, lo_nxt;
  logic [X_BITS-1:0]  qx_r, qx_nxt;
  logic [LVL_W-1:0]   level_r, level_nxt;
  logic               alloc_r, alloc_nxt;
  logic               descend_r, descend_nxt;
  logic               status_r, status_nxt;
  logic signed [63:0] best_r, best_nxt;
  logic [CNT_W-1:0]   used_r, used_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic signed [63:0] out_value_r, out_value_nxt;
  logic               out_status_r, out_status_nxt;

  // evaluator pipeline
  logic               p1_vld_r;
  logic [2:0]         p1_tag_r;
  logic signed [63:0] p1_prod_r;
  logic signed [63:0] p1_c_r;
  logic signed [63:0] ev_r [0:5];

  logic               issue;
  logic signed [31:0] mul_s;
  logic signed [63:0] mul_c;
  logic [X_BITS-1:0]  mul_x;
  logic signed [PROD_W-1:0] prod;
  logic signed [64:0] sum_w;
  logic signed [63:0] sum_sat;

  logic [BIT_W-1:0]   lvl_m1;
  logic [X_BITS-1:0]  half;
  logic [X_BITS:0]    span_w;
  logic [X_BITS-1:0]  x_left, x_right, x_mid;
  logic [2:0]         eval_last;

  logic               le_l, le_r, ge_l, ge_r, mid_win, lef_win, go_left;
  logic [IDX_W-1:0]   ins_child, q_child;

  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  logic [NODE_W-1:0]  ram_wdata;
  logic [NODE_W-1:0]  ram_rdata;

  assign busy       = (state_r != ST_IDLE);
  assign out_valid  = out_valid_r;
  assign out_value  = out_value_r;
  assign out_status = out_status_r;

  // segment [lo, lo + 2^level): end points and midpoint
  assign lvl_m1  = BIT_W'(level_r - LVL_W'(1));
  assign half    = {{(X_BITS-1){1'b0}}, 1'b1} << lvl_m1;
  assign span_w  = {half, 1'b0} - {{X_BITS{1'b0}}, 1'b1};
  assign x_left  = lo_r;
  assign x_right = (level_r == '0) ? lo_r : (lo_r | span_w[X_BITS-1:0]);
  assign x_mid   = lo_r | half;

  assign eval_last = query_r ? 3'd2 : 3'd7;

  // evaluation schedule: insert does new/old at left, right, midpoint; query does the node at qx
  always_comb begin
    mul_s = cur_s_r;
    mul_c = cur_c_r;
    mul_x = x_left;
    if (query_r) begin
      mul_s = node_r.slope;
      mul_c = node_r.icpt;
      mul_x = qx_r;
    end else begin
      case (cnt_r)
        3'd0: begin mul_s = cur_s_r;      mul_c = cur_c_r;     mul_x = x_left;  end
        3'd1: begin mul_s = node_r.slope; mul_c = node_r.icpt; mul_x = x_left;  end
        3'd2: begin mul_s = cur_s_r;      mul_c = cur_c_r;     mul_x = x_right; end
        3'd3: begin mul_s = node_r.slope; mul_c = node_r.icpt; mul_x = x_right; end
        3'd4: begin mul_s = cur_s_r;      mul_c = cur_c_r;     mul_x = x_mid;   end
        3'd5: begin mul_s = node_r.slope; mul_c = node_r.icpt; mul_x = x_mid;   end
        default: begin mul_s = cur_s_r;   mul_c = cur_c_r;     mul_x = x_left;  end
      endcase
    end
  end

  assign issue = (state_r == ST_EVAL) && (query_r ? (cnt_r == 3'd0) : (cnt_r < 3'd6));
  assign prod  = $signed(mul_s) * $signed({1'b0, mul_x});

  // saturating add toward the sign of the overflow
  assign sum_w = {p1_prod_r[63], p1_prod_r} + {p1_c_r[63], p1_c_r};
  always_comb begin
    if (sum_w[64] != sum_w[63]) begin
      sum_sat = sum_w[64] ? VAL_MIN : VAL_MAX;
    end else begin
      sum_sat = sum_w[63:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_vld_r <= 1'b0;
    end else begin
      p1_vld_r <= issue;
    end
  end

  always_ff @(posedge clk) begin
    p1_tag_r  <= cnt_r;
    p1_prod_r <= 64'(prod);
    p1_c_r    <= mul_c;
    if (p1_vld_r) begin
      ev_r[p1_tag_r] <= sum_sat;
    end
  end

  // insert decision inputs
  assign le_l    = ev_r[0] <= ev_r[1];
  assign le_r    = ev_r[2] <= ev_r[3];
  assign ge_l    = ev_r[0] >= ev_r[1];
  assign ge_r    = ev_r[2] >= ev_r[3];
  assign mid_win = ev_r[4] > ev_r[5];
  assign lef_win = ev_r[0] > ev_r[1];
  assign go_left = lef_win != mid_win;
  assign ins_child = go_left ? node_r.left : node_r.right;
  assign q_child   = qx_r[lvl_m1] ? node_r.right : node_r.left;

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    query_nxt      = query_r;
    root_nxt       = root_r;
    node_nxt       = node_r;
    cur_s_nxt      = cur_s_r;
    cur_c_nxt      = cur_c_r;
    v_nxt          = v_r;
    child_nxt      = child_r;
    lo_nxt         = lo_r;
    qx_nxt         = qx_r;
    level_nxt      = level_r;
    alloc_nxt      = alloc_r;
    descend_nxt    = descend_r;
    status_nxt     = status_r;
    best_nxt       = best_r;
    used_nxt       = used_r;
    out_valid_nxt  = 1'b0;
    out_value_nxt  = out_value_r;
    out_status_nxt = out_status_r;

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          node_nxt   = root_r;
          v_nxt      = '0;
          lo_nxt     = '0;
          level_nxt  = LVL_W'(X_BITS);
          cnt_nxt    = 3'd0;
          cur_s_nxt  = in_slope;
          cur_c_nxt  = 64'(in_intercept);
          qx_nxt     = X_BITS'(in_position);
          best_nxt   = VAL_MIN;
          status_nxt = 1'b0;
          alloc_nxt  = 1'b0;
          descend_nxt = 1'b0;
          case (cmd_t'(in_command))
            CMD_CLEAR: begin
              root_nxt       = ROOT_NODE;
              used_nxt       = CNT_W'(1);
              out_valid_nxt  = 1'b1;
              out_value_nxt  = '0;
              out_status_nxt = 1'b0;
            end
            CMD_INSERT: begin
              query_nxt = 1'b0;
              state_nxt = ST_EVAL;
            end
            CMD_QUERY: begin
              query_nxt = 1'b1;
              state_nxt = ST_EVAL;
            end
            default: begin
              out_valid_nxt  = 1'b1;
              out_value_nxt  = '0;
              out_status_nxt = 1'b0;
            end
          endcase
        end
      end

      ST_EVAL: begin
        cnt_nxt = cnt_r + 3'd1;
        if (cnt_r == eval_last) begin
          cnt_nxt = 3'd0;
          if (query_r) begin
            best_nxt = (ev_r[0] > best_r) ? ev_r[0] : best_r;
            if (level_r == '0 || q_child == '0) begin
              state_nxt      = ST_IDLE;
              out_valid_nxt  = 1'b1;
              out_value_nxt  = best_nxt;
              out_status_nxt = 1'b0;
            end else begin
              child_nxt = q_child;
              level_nxt = level_r - LVL_W'(1);
              state_nxt = ST_RD;
            end
          end else begin
            state_nxt   = ST_WB;
            alloc_nxt   = 1'b0;
            descend_nxt = 1'b0;
            if (le_l && le_r) begin
              // new line loses everywhere on the segment
            end else if (ge_l && ge_r) begin
              node_nxt.slope = cur_s_r;
              node_nxt.icpt  = cur_c_r;
            end else begin
              if (mid_win) begin
                node_nxt.slope = cur_s_r;
                node_nxt.icpt  = cur_c_r;
                cur_s_nxt      = node_r.slope;
                cur_c_nxt      = node_r.icpt;
              end
              if (level_r != '0) begin
                if (ins_child != '0) begin
                  descend_nxt = 1'b1;
                  child_nxt   = ins_child;
                  level_nxt   = level_r - LVL_W'(1);
                  if (!go_left) begin
                    lo_nxt = x_mid;
                  end
                end else if (used_r == CNT_W'(NODE_COUNT)) begin
                  status_nxt = 1'b1;
                end else begin
                  alloc_nxt = 1'b1;
                  if (go_left) begin
                    node_nxt.left = used_r[IDX_W-1:0];
                  end else begin
                    node_nxt.right = used_r[IDX_W-1:0];
                  end
                end
              end
            end
          end
        end
      end

      ST_RD: begin
        state_nxt = ST_LOAD;
      end

      ST_LOAD: begin
        node_nxt  = node_t'(ram_rdata);
        v_nxt     = child_r;
        state_nxt = ST_EVAL;
      end

      ST_WB: begin
        if (v_r == '0) begin
          root_nxt = node_r;
        end
        if (alloc_r) begin
          state_nxt = ST_ALLOC;
        end else if (descend_r) begin
          state_nxt = ST_LOAD;
        end else begin
          state_nxt      = ST_IDLE;
          out_valid_nxt  = 1'b1;
          out_value_nxt  = '0;
          out_status_nxt = status_r;
        end
      end

      ST_ALLOC: begin
        used_nxt       = used_r + CNT_W'(1);
        state_nxt      = ST_IDLE;
        out_valid_nxt  = 1'b1;
        out_value_nxt  = '0;
        out_status_nxt = 1'b0;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= 3'd0;
      query_r     <= 1'b0;
      root_r      <= ROOT_NODE;
      used_r      <= CNT_W'(1);
      alloc_r     <= 1'b0;
      descend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      query_r     <= query_nxt;
      root_r      <= root_nxt;
      used_r      <= used_nxt;
      alloc_r     <= alloc_nxt;
      descend_r   <= descend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    node_r       <= node_nxt;
    cur_s_r      <= cur_s_nxt;
    cur_c_r      <= cur_c_nxt;
    v_r          <= v_nxt;
    child_r      <= child_nxt;
    lo_r         <= lo_nxt;
    qx_r         <= qx_nxt;
    level_r      <= level_nxt;
    status_r     <= status_nxt;
    best_r       <= best_nxt;
    out_value_r  <= out_value_nxt;
    out_status_r <= out_status_nxt;
  end

  // node pool; entry 0 is unused, the root is held in root_r
  assign ram_we    = ((state_r == ST_WB) && (v_r != '0)) || (state_r == ST_ALLOC);
  assign ram_waddr = (state_r == ST_ALLOC) ? used_r[IDX_W-1:0] : v_r;
  assign ram_wdata = (state_r == ST_ALLOC) ? {cur_s_r, cur_c_r, {IDX_W{1'b0}}, {IDX_W{1'b0}}}
                                           : node_r;

  mlet_ram #(
    .WIDTH (NODE_W),
    .DEPTH (NODE_COUNT)
  ) u_node_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (child_r),
    .rdata (ram_rdata)
  );

  a_result_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while busy");

  a_status_only_insert: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status) |-> (out_value == 64'sd0))
    else $error("overflow status with nonzero value");

  a_long_cmd_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_command == CMD_INSERT || in_command == CMD_QUERY))
      |=> (busy && !out_valid))
    else $error("insert or query did not go busy");

  a_clear_root: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_command == CMD_CLEAR)
      |=> (out_valid && used_r == CNT_W'(1) && root_r.icpt == ROOT_ICPT))
    else $error("clear did not reset the pool");

  a_pool_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> ((used_r != '0) && (used_r <= CNT_W'(NODE_COUNT))))
    else $error("node pool count out of range");

endmodule
